// ----- design/efl_pkg.sv -----
// efl_pkg: shared constants, register codes and item types of the 3x3 edge filter.
// No dependencies; imported by every module of the block except efl_ram.
package efl_pkg;

  localparam int PIX_W      = 12;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int ADDR_W     = $clog2(MAX_WIDTH);
  localparam int WID_W      = 11;
  localparam int HGT_W      = 13;
  localparam int COL_W      = 11;
  localparam int ROW_W      = 14;
  localparam int VAL_W      = 16;
  localparam int MAG_W      = 15;
  localparam int SQ_W       = 2 * MAG_W;
  localparam int RAD_W      = 32;
  localparam int ROOT_W     = RAD_W / 2;
  localparam int REM_W      = ROOT_W + 3;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int PADDR_W    = 4;

  localparam logic [1:0] MODE_PREWITT = 2'd0;
  localparam logic [1:0] MODE_SOBEL   = 2'd1;
  localparam logic [1:0] MODE_LAPLACE = 2'd2;

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef struct packed {
    logic             op;
    logic [PIX_W-1:0] pixel;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    frame_end;
  } out_item_t;

  // one 3x3 window ready for the arithmetic, entry r*3+c
  typedef struct packed {
    logic [8:0][PIX_W-1:0] win;
    logic                  border;
    logic                  frame_end;
  } win_item_t;

endpackage

// ----- design/efl_ram.sv -----
// efl_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module efl_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [0:DEPTH-1];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/efl_fifo.sv -----
// efl_fifo: short window queue between the front and the arithmetic back end.
// Depends on efl_pkg.
module efl_fifo import efl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  win_item_t             push_data,
  input  logic                  pop,
  output win_item_t             head,
  output logic [FIFO_CNT_W-1:0] count
);

  win_item_t             mem_r [0:FIFO_DEPTH-1];
  logic [FIFO_PTR_W-1:0] wp_r, rp_r;
  logic [FIFO_CNT_W-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!push && pop) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  assign head  = mem_r[rp_r];
  assign count = cnt_r;

endmodule

// ----- design/efl_front.sv -----
// efl_front: accepts items, tracks raster position, holds the two line stores
// and the 3x3 window, and queues windows that produce a result. Uses efl_pkg, efl_ram.
module efl_front import efl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  input  logic [WID_W-1:0]      width_cfg,
  input  logic [HGT_W-1:0]      height_cfg,
  input  logic                  restart,
  input  logic [FIFO_CNT_W-1:0] fifo_cnt,
  output logic                  push,
  output win_item_t             push_data
);

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] ecol_r, ecol_nxt;
  logic [HGT_W-1:0] erow_r, erow_nxt;

  logic             s1_vld_r;
  logic [ADDR_W-1:0] s1_x_r;
  logic [PIX_W-1:0] s1_pix_r;
  logic             s1_emit_r, s1_border_r, s1_fe_r;
  logic             bp_r;
  logic [PIX_W-1:0] bp_a_r, bp_b_r;
  logic [8:0][PIX_W-1:0] win_r, win_nxt;

  logic [COL_W-1:0] w_eff, x, pcol;
  logic [HGT_W-1:0] h_eff;
  logic [ROW_W-1:0] prow;
  logic             acc, in_done, work, emit, border, fe;
  logic [PIX_W-1:0] pix, up_rd, mid_rd, a, b;
  logic [COL_W-1:0] col_inc;

  always_comb begin
    if (width_cfg < COL_W'(3))              w_eff = COL_W'(3);
    else if (width_cfg > COL_W'(MAX_WIDTH)) w_eff = COL_W'(MAX_WIDTH);
    else                                    w_eff = width_cfg;
    if (height_cfg < HGT_W'(3))               h_eff = HGT_W'(3);
    else if (height_cfg > HGT_W'(MAX_HEIGHT)) h_eff = HGT_W'(MAX_HEIGHT);
    else                                      h_eff = height_cfg;
  end

  assign in_ready = (fifo_cnt + FIFO_CNT_W'(s1_vld_r)) < FIFO_CNT_W'(FIFO_DEPTH);
  assign acc      = in_valid && in_ready;
  assign in_done  = row_r >= ROW_W'(h_eff);
  // flush before the last pixel is dropped; after it, every item drains
  assign work     = acc && (in_done || (in_data.op == OP_PIXEL));
  assign pix      = in_done ? '0 : in_data.pixel;
  assign x        = (col_r >= w_eff) ? '0 : col_r;
  assign emit     = !((row_r == '0) || ((row_r == ROW_W'(1)) && (x == '0)));

  always_comb begin
    if (x != '0) begin
      prow = row_r - 1'b1;
      pcol = x - 1'b1;
    end else begin
      prow = row_r - ROW_W'(2);
      pcol = w_eff - 1'b1;
    end
  end

  assign border = (prow == '0) || (prow >= ROW_W'(h_eff) - 1'b1) ||
                  (pcol == '0) || (pcol >= w_eff - 1'b1);
  assign fe     = emit && (ecol_r == w_eff - 1'b1) && (erow_r == h_eff - 1'b1);
  assign col_inc = x + 1'b1;

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    ecol_nxt = ecol_r;
    erow_nxt = erow_r;
    if (restart || (work && fe)) begin
      col_nxt  = '0;
      row_nxt  = '0;
      ecol_nxt = '0;
      erow_nxt = '0;
    end else if (work) begin
      if (col_inc >= w_eff) begin
        col_nxt = '0;
        row_nxt = row_r + 1'b1;
      end else begin
        col_nxt = col_inc;
      end
      if (emit) begin
        if (ecol_r == w_eff - 1'b1) begin
          ecol_nxt = '0;
          erow_nxt = erow_r + 1'b1;
        end else begin
          ecol_nxt = ecol_r + 1'b1;
        end
      end
    end
  end

  efl_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
    .clk(clk), .we(s1_vld_r), .waddr(s1_x_r), .wdata(b),
    .re(work), .raddr(x[ADDR_W-1:0]), .rdata(up_rd)
  );

  efl_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
    .clk(clk), .we(s1_vld_r), .waddr(s1_x_r), .wdata(s1_pix_r),
    .re(work), .raddr(x[ADDR_W-1:0]), .rdata(mid_rd)
  );

  // same column read right after its write (frame wrap): forward
  assign a = bp_r ? bp_a_r : up_rd;
  assign b = bp_r ? bp_b_r : mid_rd;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_nxt[r*3]   = win_r[r*3+1];
      win_nxt[r*3+1] = win_r[r*3+2];
    end
    win_nxt[2] = a;
    win_nxt[5] = b;
    win_nxt[8] = s1_pix_r;
  end

  assign push                = s1_vld_r && s1_emit_r;
  assign push_data.win       = win_nxt;
  assign push_data.border    = s1_border_r;
  assign push_data.frame_end = s1_fe_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      ecol_r   <= '0;
      erow_r   <= '0;
      s1_vld_r <= 1'b0;
      bp_r     <= 1'b0;
      win_r    <= '0;
    end else begin
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      ecol_r   <= ecol_nxt;
      erow_r   <= erow_nxt;
      s1_vld_r <= work;
      if (work) begin
        bp_r <= s1_vld_r && (s1_x_r == x[ADDR_W-1:0]);
      end
      if (s1_vld_r) begin
        win_r <= win_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (work) begin
      s1_x_r      <= x[ADDR_W-1:0];
      s1_pix_r    <= pix;
      s1_emit_r   <= emit;
      s1_border_r <= border;
      s1_fe_r     <= fe;
      bp_a_r      <= b;
      bp_b_r      <= s1_pix_r;
    end
  end

endmodule

// ----- design/efl_back.sv -----
// efl_back: kernel sums, squares and a pipelined integer square root, then the
// output register. Uses efl_pkg.
module efl_back import efl_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [1:0]      mode,
  input  logic            head_vld,
  input  win_item_t       head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output out_item_t       out_data
);

  localparam int NST = ROOT_W;

  logic en;
  logic signed [VAL_W-1:0] p [0:8];
  logic signed [VAL_W-1:0] gx, gy, lap, agx, agy;
  logic                    is_lap;

  logic                    b1_vld_r, b1_lap_f_r, b1_fe_r;
  logic [MAG_W-1:0]        b1_mx_r, b1_my_r;
  logic signed [VAL_W-1:0] b1_lap_r;
  logic                    b2_vld_r, b2_lap_f_r, b2_fe_r;
  logic [SQ_W-1:0]         b2_sx_r, b2_sy_r;
  logic signed [VAL_W-1:0] b2_lap_r;

  logic                    sq_vld_r [0:NST];
  logic                    sq_lf_r  [0:NST];
  logic                    sq_fe_r  [0:NST];
  logic signed [VAL_W-1:0] sq_lap_r [0:NST];
  logic [RAD_W-1:0]        sq_n_r   [0:NST];
  logic [REM_W-1:0]        sq_rem_r [0:NST];
  logic [ROOT_W-1:0]       sq_root_r[0:NST];
  logic [RAD_W-1:0]        n_nx   [0:NST-1];
  logic [REM_W-1:0]        rem_nx [0:NST-1];
  logic [ROOT_W-1:0]       root_nx[0:NST-1];

  logic                    out_valid_r;
  out_item_t               out_data_r;

  assign en  = !out_valid_r || out_ready;
  assign pop = en && head_vld;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      p[i] = $signed(VAL_W'(head.win[i]));
    end
    is_lap = (mode != MODE_PREWITT) && (mode != MODE_SOBEL);
    if (mode == MODE_PREWITT) begin
      gx = p[0] + p[3] + p[6] - p[2] - p[5] - p[8];
      gy = p[0] + p[1] + p[2] - p[6] - p[7] - p[8];
    end else begin
      gx = p[2] + (p[5] <<< 1) + p[8] - p[0] - (p[3] <<< 1) - p[6];
      gy = p[0] + (p[1] <<< 1) + p[2] - p[6] - (p[7] <<< 1) - p[8];
    end
    lap = p[1] + p[3] + p[5] + p[7] - (p[4] <<< 2);
    if (head.border) begin
      // border: sqrt(2c^2) falls out of gx = gy = c
      gx  = p[4];
      gy  = p[4];
      lap = p[4];
    end
    agx = (gx < 0) ? -gx : gx;
    agy = (gy < 0) ? -gy : gy;
  end

  // one result bit per stage, restoring method
  always_comb begin
    logic [REM_W-1:0] rs, tr;
    for (int k = 0; k < NST; k++) begin
      rs = {sq_rem_r[k][REM_W-3:0], sq_n_r[k][RAD_W-1 -: 2]};
      tr = {1'b0, sq_root_r[k], 2'b01};
      n_nx[k] = sq_n_r[k] << 2;
      if (rs >= tr) begin
        rem_nx[k]  = rs - tr;
        root_nx[k] = {sq_root_r[k][ROOT_W-2:0], 1'b1};
      end else begin
        rem_nx[k]  = rs;
        root_nx[k] = {sq_root_r[k][ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_vld_r    <= 1'b0;
      b2_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k <= NST; k++) begin
        sq_vld_r[k] <= 1'b0;
      end
    end else if (en) begin
      b1_vld_r    <= head_vld;
      b2_vld_r    <= b1_vld_r;
      sq_vld_r[0] <= b2_vld_r;
      for (int k = 0; k < NST; k++) begin
        sq_vld_r[k+1] <= sq_vld_r[k];
      end
      out_valid_r <= sq_vld_r[NST];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_mx_r     <= agx[MAG_W-1:0];
      b1_my_r     <= agy[MAG_W-1:0];
      b1_lap_r    <= lap;
      b1_lap_f_r  <= is_lap;
      b1_fe_r     <= head.frame_end;
      b2_sx_r     <= b1_mx_r * b1_mx_r;
      b2_sy_r     <= b1_my_r * b1_my_r;
      b2_lap_r    <= b1_lap_r;
      b2_lap_f_r  <= b1_lap_f_r;
      b2_fe_r     <= b1_fe_r;
      sq_n_r[0]    <= RAD_W'(b2_sx_r) + RAD_W'(b2_sy_r);
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
      sq_lap_r[0]  <= b2_lap_r;
      sq_lf_r[0]   <= b2_lap_f_r;
      sq_fe_r[0]   <= b2_fe_r;
      for (int k = 0; k < NST; k++) begin
        sq_n_r[k+1]    <= n_nx[k];
        sq_rem_r[k+1]  <= rem_nx[k];
        sq_root_r[k+1] <= root_nx[k];
        sq_lap_r[k+1]  <= sq_lap_r[k];
        sq_lf_r[k+1]   <= sq_lf_r[k];
        sq_fe_r[k+1]   <= sq_fe_r[k];
      end
      out_data_r.value     <= sq_lf_r[NST] ? sq_lap_r[NST] : $signed(sq_root_r[NST]);
      out_data_r.frame_end <= sq_fe_r[NST];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- design/edge_filter_3x3_core.sv -----
// edge_filter_3x3_core: top level of the streaming 3x3 edge filter.
// Depends on efl_pkg, efl_front, efl_fifo, efl_back (and efl_ram below the front).
//
// Usage:
//  - in_* channel (valid/ready) carries one item per transfer: op = pixel
//    brings the next raster pixel, op = flush pushes one pending result out
//    once the frame's last pixel is in (earlier flushes are swallowed).
//  - out_* channel carries one filtered result per emitting item;
//    frame_end marks the last result of a frame, after which the raster
//    position restarts at zero.
//  - The result for raster position p comes from the item that brings
//    position p + width + 1; send width + 1 flushes to drain a frame.
//  - Throughput: one item per clock while in_ready is high. The front reads
//    both line-store RAMs in the accept cycle and updates the window the next;
//    the back end pipeline is 20 registers (sums, squares, radicand, 16 root stages, output).
//  - From accept to out_valid an item passes the line stores, window queue and back end.
//  - A stall on out_ready freezes the back end; the 4-entry window queue
//    then fills and in_ready drops, so nothing is lost.
//  - Reset (rst_n low, synchronous): mode Sobel, width 640, height 480,
//    window cleared, position zero. Line stores are not cleared.
//  - APB: 0x0 mode, 0x4 width, 0x8 height. Width/height writes restart the
//    frame; write only while idle.
module edge_filter_3x3_core import efl_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [1:0]       mode_r;
  logic [WID_W-1:0] width_r;
  logic [HGT_W-1:0] height_r;
  logic             wr, restart;
  logic [1:0]       reg_idx;

  logic                  fifo_push, fifo_pop;
  win_item_t             fifo_in, fifo_head;
  logic [FIFO_CNT_W-1:0] fifo_cnt;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr      = psel && penable && pwrite && pready;
  // geometry change starts a fresh frame
  assign restart = wr && ((reg_idx == REG_WIDTH) || (reg_idx == REG_HEIGHT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_SOBEL;
      width_r  <= WID_W'(640);
      height_r <= HGT_W'(480);
    end else if (wr) begin
      case (reg_idx)
        REG_MODE:   mode_r   <= pwdata[1:0];
        REG_WIDTH:  width_r  <= pwdata[WID_W-1:0];
        REG_HEIGHT: height_r <= pwdata[HGT_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MODE:   prdata = 32'(mode_r);
      REG_WIDTH:  prdata = 32'(width_r);
      REG_HEIGHT: prdata = 32'(height_r);
      default:    prdata = '0;
    endcase
  end

  efl_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .width_cfg(width_r), .height_cfg(height_r), .restart(restart),
    .fifo_cnt(fifo_cnt), .push(fifo_push), .push_data(fifo_in)
  );

  efl_fifo u_fifo (
    .clk(clk), .rst_n(rst_n),
    .push(fifo_push), .push_data(fifo_in),
    .pop(fifo_pop), .head(fifo_head), .count(fifo_cnt)
  );

  efl_back u_back (
    .clk(clk), .rst_n(rst_n), .mode(mode_r),
    .head_vld(fifo_cnt != '0), .head(fifo_head), .pop(fifo_pop),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

`ifndef NO_ASSERTIONS
  // front reservation must keep the queue from overflowing
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_push |-> (fifo_cnt < FIFO_CNT_W'(FIFO_DEPTH)))
    else $error("window queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_pop |-> (fifo_cnt != '0))
    else $error("window queue underflow");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");
`endif

endmodule
